FILE: rtl/core/ssip_pkg.sv
// Package of shared types, register indexes and command codes for the serial setpoint PID.
`default_nettype none

package ssip_pkg;

	// Fixed point format of the gains and the drive accumulator.
	localparam int GAIN_FRAC_BITS = 12;
	localparam int GAIN_W         = 16;
	localparam int ACC_W          = 8 + GAIN_FRAC_BITS;

	// Error and difference widths (signed).
	localparam int ERR_W  = 9;
	localparam int DP_W   = ERR_W + 1;
	localparam int DD_W   = ERR_W + 2;
	localparam int PROD_W = GAIN_W + 1 + DD_W;
	localparam int SUM_W  = ((PROD_W > ACC_W + 1) ? PROD_W : ACC_W + 1) + 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KP_INITIAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_INITIAL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_INITIAL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_MODE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KD_MODE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KI_OUTER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KI_MIDDLE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR = 3'd7;

	// Serial framing and command codes.
	localparam logic [7:0]  FRAME_END  = 8'h3B;
	localparam logic [15:0] CODE_UP    = 16'h7570;
	localparam logic [15:0] CODE_DOWN  = 16'h776E;
	localparam logic [15:0] CODE_RIGHT = 16'h6874;
	localparam logic [15:0] CODE_LEFT  = 16'h6674;
	localparam logic [2:0]  COUNT_MAX  = 3'd7;

	// Setpoints in cm.
	localparam logic [5:0] SETPOINT_OFF    = 6'd0;
	localparam logic [5:0] SETPOINT_NEAR   = 6'd20;
	localparam logic [5:0] SETPOINT_MIDDLE = 6'd30;
	localparam logic [5:0] SETPOINT_FAR    = 6'd40;

	// Gain set codes.
	localparam logic [1:0] GAIN_INITIAL = 2'd0;
	localparam logic [1:0] GAIN_OUTER   = 2'd1;
	localparam logic [1:0] GAIN_MIDDLE  = 2'd2;

	// Item kinds.
	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic [GAIN_W-1:0] kp_initial;
		logic [GAIN_W-1:0] ki_initial;
		logic [GAIN_W-1:0] kd_initial;
		logic [GAIN_W-1:0] kp_mode;
		logic [GAIN_W-1:0] kd_mode;
		logic [GAIN_W-1:0] ki_outer;
		logic [GAIN_W-1:0] ki_middle;
		logic [7:0]        drive_floor;
	} cfg_t;

	typedef struct packed {
		logic [5:0] target;
		logic       taken;
	} frame_res_t;

	typedef struct packed {
		logic [7:0] duty;
		logic [1:0] gain;
	} pid_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssip_cfg.sv
// Configuration register bank: gains and drive floor, written through a plain write port.
`default_nettype none

module ssip_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ssip_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ssip_pkg::CFG_DATA_W-1:0]   cfg_data,
	output ssip_pkg::cfg_t                         cfg
);

	ssip_pkg::cfg_t cfg_q;

	// Register writes; reset loads the default tuning.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_initial  <= 16'd4096;
			cfg_q.ki_initial  <= 16'd4096;
			cfg_q.kd_initial  <= 16'd1229;
			cfg_q.kp_mode     <= 16'd3994;
			cfg_q.kd_mode     <= 16'd1095;
			cfg_q.ki_outer    <= 16'd1638;
			cfg_q.ki_middle   <= 16'd1939;
			cfg_q.drive_floor <= 8'd110;
		end else if (cfg_we) begin
			case (cfg_index)
				ssip_pkg::REG_KP_INITIAL:  cfg_q.kp_initial  <= cfg_data;
				ssip_pkg::REG_KI_INITIAL:  cfg_q.ki_initial  <= cfg_data;
				ssip_pkg::REG_KD_INITIAL:  cfg_q.kd_initial  <= cfg_data;
				ssip_pkg::REG_KP_MODE:     cfg_q.kp_mode     <= cfg_data;
				ssip_pkg::REG_KD_MODE:     cfg_q.kd_mode     <= cfg_data;
				ssip_pkg::REG_KI_OUTER:    cfg_q.ki_outer    <= cfg_data;
				ssip_pkg::REG_KI_MIDDLE:   cfg_q.ki_middle   <= cfg_data;
				ssip_pkg::REG_DRIVE_FLOOR: cfg_q.drive_floor <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/ssip_frame.sv
// Serial frame collector and command decoder that owns the setpoint.
`default_nettype none

module ssip_frame (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    rx_byte,
	output logic [5:0]         target,
	output ssip_pkg::frame_res_t res
);

	logic [2:0] count_q;
	logic [7:0] byte0_q;
	logic [7:0] byte1_q;
	logic [5:0] target_q;

	logic [2:0]  count_nx;
	logic [5:0]  target_nx;
	logic        taken_nx;
	logic [15:0] code;
	logic        is_end;

	assign is_end = (rx_byte == ssip_pkg::FRAME_END);
	assign code   = {byte0_q, byte1_q};

	// Next count, setpoint and command flag for one byte.
	always_comb begin
		count_nx  = count_q;
		target_nx = target_q;
		taken_nx  = 1'b0;
		if (!is_end) begin
			if (count_q < ssip_pkg::COUNT_MAX) begin
				count_nx = count_q + 3'd1;
			end
		end else begin
			count_nx = 3'd0;
			if (count_q == 3'd2) begin
				case (code)
					ssip_pkg::CODE_UP: begin
						target_nx = ssip_pkg::SETPOINT_NEAR;
						taken_nx  = 1'b1;
					end
					ssip_pkg::CODE_DOWN: begin
						target_nx = ssip_pkg::SETPOINT_MIDDLE;
						taken_nx  = 1'b1;
					end
					ssip_pkg::CODE_LEFT: begin
						target_nx = ssip_pkg::SETPOINT_FAR;
						taken_nx  = 1'b1;
					end
					ssip_pkg::CODE_RIGHT: begin
						target_nx = ssip_pkg::SETPOINT_OFF;
						taken_nx  = 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Frame state; only the first two bytes of a frame are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 3'd0;
			byte0_q  <= 8'd0;
			byte1_q  <= 8'd0;
			target_q <= ssip_pkg::SETPOINT_OFF;
		end else if (step) begin
			count_q  <= count_nx;
			target_q <= target_nx;
			if (!is_end && count_q == 3'd0) begin
				byte0_q <= rx_byte;
			end
			if (!is_end && count_q == 3'd1) begin
				byte1_q <= rx_byte;
			end
		end
	end

	assign target     = target_q;
	assign res.target = step ? target_nx : target_q;
	assign res.taken  = step & taken_nx;

endmodule

`default_nettype wire

FILE: rtl/core/ssip_pid.sv
// Incremental PID update: gain selection, three products, accumulate and clamp.
`default_nettype none

module ssip_pid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [5:0]    target,
	input  wire logic [7:0]    distance_cm,
	input  ssip_pkg::cfg_t     cfg,
	output ssip_pkg::pid_res_t res
);

	localparam int ERR_W  = ssip_pkg::ERR_W;
	localparam int DP_W   = ssip_pkg::DP_W;
	localparam int DD_W   = ssip_pkg::DD_W;
	localparam int PROD_W = ssip_pkg::PROD_W;
	localparam int SUM_W  = ssip_pkg::SUM_W;
	localparam int ACC_W  = ssip_pkg::ACC_W;
	localparam int FRAC   = ssip_pkg::GAIN_FRAC_BITS;
	localparam int GAIN_W = ssip_pkg::GAIN_W;

	logic [1:0]              gain_q;
	logic signed [ERR_W-1:0] e1_q;
	logic signed [ERR_W-1:0] e2_q;
	logic [ACC_W-1:0]        acc_q;

	logic [1:0]              gain_nx;
	logic [GAIN_W-1:0]       kp;
	logic [GAIN_W-1:0]       ki;
	logic [GAIN_W-1:0]       kd;
	logic signed [ERR_W-1:0] e0;
	logic signed [DP_W-1:0]  d_p;
	logic signed [DD_W-1:0]  d_d;
	logic signed [PROD_W-1:0] p_p;
	logic signed [PROD_W-1:0] p_i;
	logic signed [PROD_W-1:0] p_d;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] floor_val;
	logic signed [SUM_W-1:0] acc_max;
	logic signed [SUM_W-1:0] clamped;
	logic [ACC_W-1:0]        acc_nx;

	// Gain set follows the setpoint; the off setpoint keeps the set in use.
	always_comb begin
		gain_nx = gain_q;
		if (target == ssip_pkg::SETPOINT_MIDDLE) begin
			gain_nx = ssip_pkg::GAIN_MIDDLE;
		end else if (target == ssip_pkg::SETPOINT_NEAR || target == ssip_pkg::SETPOINT_FAR) begin
			gain_nx = ssip_pkg::GAIN_OUTER;
		end
	end

	// Gains of the chosen set.
	always_comb begin
		case (gain_nx)
			ssip_pkg::GAIN_MIDDLE: begin
				kp = cfg.kp_mode;
				ki = cfg.ki_middle;
				kd = cfg.kd_mode;
			end
			ssip_pkg::GAIN_OUTER: begin
				kp = cfg.kp_mode;
				ki = cfg.ki_outer;
				kd = cfg.kd_mode;
			end
			default: begin
				kp = cfg.kp_initial;
				ki = cfg.ki_initial;
				kd = cfg.kd_initial;
			end
		endcase
	end

	// Error and its first and second differences.
	assign e0  = $signed(ERR_W'(target)) - $signed(ERR_W'(distance_cm));
	assign d_p = DP_W'(e0) - DP_W'(e1_q);
	assign d_d = DD_W'(e0) - (DD_W'(e1_q) <<< 1) + DD_W'(e2_q);

	// Exact products of unsigned gains with signed differences.
	assign p_p = PROD_W'($signed({1'b0, kp})) * PROD_W'(d_p);
	assign p_i = PROD_W'($signed({1'b0, ki})) * PROD_W'(e0);
	assign p_d = PROD_W'($signed({1'b0, kd})) * PROD_W'(d_d);

	assign sum = $signed(SUM_W'(acc_q)) + SUM_W'(p_p) + SUM_W'(p_i) + SUM_W'(p_d);

	// Clamp to the drive floor below and to all ones above.
	assign floor_val = $signed(SUM_W'({cfg.drive_floor, {FRAC{1'b0}}}));
	assign acc_max   = $signed(SUM_W'({ACC_W{1'b1}}));

	always_comb begin
		clamped = sum;
		if (sum < floor_val) begin
			clamped = floor_val;
		end
		if (clamped > acc_max) begin
			clamped = acc_max;
		end
	end

	assign acc_nx = clamped[ACC_W-1:0];

	// Loop state advances on each distance sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ssip_pkg::GAIN_INITIAL;
			e1_q   <= '0;
			e2_q   <= '0;
			acc_q  <= '0;
		end else if (step) begin
			gain_q <= gain_nx;
			e1_q   <= e0;
			e2_q   <= e1_q;
			acc_q  <= acc_nx;
		end
	end

	assign res.duty = step ? acc_nx[ACC_W-1 -: 8] : acc_q[ACC_W-1 -: 8];
	assign res.gain = step ? gain_nx : gain_q;

endmodule

`default_nettype wire

FILE: rtl/core/serial_setpoint_incremental_pid.sv
// Top level of the serial setpoint incremental PID controller.
// Each beat on the input is a serial byte or a distance sample and gives exactly one result
// beat. The block takes one beat per clock cycle when the output is not stalled. An accepted
// beat is held in the input register and then moves into the result register, which
// presents its result. The PID update is combinational: three gain products, the
// accumulate and the clamp sit between the input and result registers.
// Configuration writes take effect on the next cycle and should be made while idle.
`default_nettype none

module serial_setpoint_incremental_pid (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ssip_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ssip_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              op,
	input  wire logic [7:0]                        rx_byte,
	input  wire logic [7:0]                        distance_cm,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [5:0]                             setpoint_cm,
	output logic [7:0]                             drive_duty,
	output logic [1:0]                             gain_set,
	output logic                                   command_taken
);

	ssip_pkg::cfg_t       cfg;
	ssip_pkg::frame_res_t frame_res;
	ssip_pkg::pid_res_t   pid_res;
	logic [5:0]           target;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] rx_byte_s1;
	logic [7:0] dist_s1;

	logic       out_valid_q;
	logic [5:0] setpoint_q;
	logic [7:0] duty_q;
	logic [1:0] gain_q;
	logic       taken_q;

	logic advance;

	// The input stage moves on whenever the result register is free or being emptied.
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	ssip_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssip_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance & (op_s1 == ssip_pkg::OP_BYTE)),
		.rx_byte (rx_byte_s1),
		.target  (target),
		.res     (frame_res)
	);

	ssip_pid u_pid (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance & (op_s1 == ssip_pkg::OP_SAMPLE)),
		.target      (target),
		.distance_cm (dist_s1),
		.cfg         (cfg),
		.res         (pid_res)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op;
			rx_byte_s1 <= rx_byte;
			dist_s1    <= distance_cm;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			setpoint_q <= frame_res.target;
			duty_q     <= pid_res.duty;
			gain_q     <= pid_res.gain;
			taken_q    <= frame_res.taken;
		end
	end

	assign out_valid     = out_valid_q;
	assign setpoint_cm   = setpoint_q;
	assign drive_duty    = duty_q;
	assign gain_set      = gain_q;
	assign command_taken = taken_q;

	// A beat leaving the input stage always lands in the result register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register empty after a beat advanced");

	// A distance sample never reports a command.
	a_sample_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == ssip_pkg::OP_SAMPLE |=> !taken_q)
		else $error("command flagged on a distance sample");

	// Only a terminator can complete a command.
	a_cmd_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == ssip_pkg::OP_BYTE && rx_byte_s1 != ssip_pkg::FRAME_END
		|=> !taken_q)
		else $error("command flagged on a non-terminator byte");

	// After a sample the drive is never below the floor.
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == ssip_pkg::OP_SAMPLE |=> duty_q >= $past(cfg.drive_floor))
		else $error("drive below floor after a sample");

endmodule

`default_nettype wire
